// ===== rtl/hsl2rgb_pkg.sv =====
package hsl2rgb_pkg;

  // Fixed-point format of the fractions and width of one color channel.
  localparam int FRAC_BITS    = 12;
  localparam int CHANNEL_BITS = 8;

  // Input fractions carry one integer bit so that 1.0 and hue up to 1.5 fit.
  localparam int IN_W   = FRAC_BITS + 1;
  // Ramp slope factor 6*t reaches just above 1.0 with the rounded breakpoints.
  localparam int F_W    = IN_W + 1;
  // Channel numerator, a fraction with 2*FRAC_BITS fraction bits.
  localparam int NUM_W  = 2 * FRAC_BITS + 2;
  localparam int PROD_W = NUM_W + CHANNEL_BITS;
  localparam int SCL_W  = PROD_W - 2 * FRAC_BITS;

  localparam logic [IN_W-1:0] ONE        = IN_W'(1 << FRAC_BITS);
  localparam logic [IN_W-1:0] HALF       = IN_W'(1 << (FRAC_BITS - 1));
  localparam logic [IN_W-1:0] THIRD      = IN_W'(((333 << FRAC_BITS) + 500) / 1000);
  localparam logic [IN_W-1:0] SIXTH      = IN_W'(((167 << FRAC_BITS) + 500) / 1000);
  localparam logic [IN_W-1:0] TWO_THIRDS = IN_W'(((667 << FRAC_BITS) + 500) / 1000);
  localparam logic [IN_W-1:0] HUE_MAX    = IN_W'((3 * (1 << FRAC_BITS)) / 2 - 1);

  localparam logic [CHANNEL_BITS-1:0] CMAX = CHANNEL_BITS'((1 << CHANNEL_BITS) - 1);

  typedef struct packed {
    logic [IN_W-1:0] hue;
    logic [IN_W-1:0] saturation;
    logic [IN_W-1:0] lightness;
  } hsl_in_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rgb_out_t;

endpackage

// ===== rtl/hsl_to_rgb_converter_unit.sv =====
// HSL to RGB color converter.
//
// Input channel (in_valid / in_stall / in_data): one color per item, hue in
// turns and saturation and lightness from 0 to 1.0, all unsigned with 12
// fraction bits. Out-of-range hue, saturation or lightness saturate.
// Result channel (out_valid / out_stall / out_data): 8-bit red, green and
// blue for every input item, in input order.
//
// The datapath is a five-stage pipeline: clamp and lightness*saturation
// product, q/p and hue wrap, breakpoint selection, ramp multiply-add, and
// the scale by 255 into the output register. Throughput is one item per
// cycle while the result side does not stall.
//
// Each stage holds a valid bit and moves forward when the stage after it is
// empty or moving, so a stall on the result side holds the output item and
// lets bubbles in front of it close before in_stall is raised. No item is
// dropped or repeated while stalled.
// Reset (synchronous, active low) empties every stage; payload registers
// are not reset.
module hsl_to_rgb_converter_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hsl2rgb_pkg::hsl_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hsl2rgb_pkg::rgb_out_t out_data
);
  import hsl2rgb_pkg::*;

  // Stage valid bits and per-stage advance enables.
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // Stage 1: clamped inputs and lightness*saturation.
  logic [IN_W-1:0]   h1_r, s1_r, l1_r;
  logic [IN_W-1:0]   h1_nxt, s1_nxt, l1_nxt;
  logic [2*IN_W-1:0] ls1_r, ls1_nxt;

  // Stage 2: q, p and the wrapped hue of each channel (red, green, blue).
  logic [IN_W-1:0] q2_r, p2_r, q2_nxt, p2_nxt;
  logic [IN_W-1:0] t2_r [3];
  logic [IN_W-1:0] t2_nxt [3];

  // Stage 3: base level, ramp factor and q-p.
  logic [IN_W-1:0] d3_r, d3_nxt;
  logic [IN_W-1:0] base3_r [3];
  logic [IN_W-1:0] base3_nxt [3];
  logic [F_W-1:0]  f3_r [3];
  logic [F_W-1:0]  f3_nxt [3];

  // Stage 4: channel numerators.
  logic [NUM_W-1:0] num4_r [3];
  logic [NUM_W-1:0] num4_nxt [3];

  // Stage 5: output register.
  logic [CHANNEL_BITS-1:0] ch5_r [3];
  logic [CHANNEL_BITS-1:0] ch5_nxt [3];

  // A stage advances when the one after it is empty or advancing itself.
  assign rdy5     = !out_valid_r || !out_stall;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  assign out_valid      = out_valid_r;
  assign out_data.red   = ch5_r[0];
  assign out_data.green = ch5_r[1];
  assign out_data.blue  = ch5_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r        <= in_valid;
      if (rdy2) v2_r        <= v1_r;
      if (rdy3) v3_r        <= v2_r;
      if (rdy4) v4_r        <= v3_r;
      if (rdy5) out_valid_r <= v4_r;
    end
  end

  // Stage 1: saturate the inputs, then one 13x13 product.
  always_comb begin
    h1_nxt  = (in_data.hue > HUE_MAX) ? HUE_MAX : in_data.hue;
    s1_nxt  = (in_data.saturation > ONE) ? ONE : in_data.saturation;
    l1_nxt  = (in_data.lightness > ONE) ? ONE : in_data.lightness;
    ls1_nxt = s1_nxt * l1_nxt;
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      h1_r  <= h1_nxt;
      s1_r  <= s1_nxt;
      l1_r  <= l1_nxt;
      ls1_r <= ls1_nxt;
    end
  end

  // Stage 2: q = l*(1+s) below half lightness, else l+s-l*s; p = 2l-q.
  // Zero saturation needs no special path: q and p both come out as l.
  logic [IN_W-1:0] lsf;
  logic [IN_W:0]   q_w;
  logic [IN_W+1:0] p_w;
  logic [IN_W:0]   red_w, blue_w;

  always_comb begin
    lsf = ls1_r[FRAC_BITS +: IN_W];
    if (l1_r < HALF) begin
      q_w = {1'b0, l1_r} + {1'b0, lsf};
    end else begin
      q_w = {1'b0, l1_r} + {1'b0, s1_r} - {1'b0, lsf};
    end
    q2_nxt = q_w[IN_W-1:0];
    p_w    = {1'b0, l1_r, 1'b0} - {2'b00, q2_nxt};
    p2_nxt = p_w[IN_W+1] ? '0 : p_w[IN_W-1:0];

    // Each shifted hue wraps once into 0..1.
    red_w = {1'b0, h1_r} + {1'b0, THIRD};
    if (red_w > {1'b0, ONE}) begin
      red_w = red_w - {1'b0, ONE};
    end
    t2_nxt[0] = red_w[IN_W-1:0];

    t2_nxt[1] = (h1_r > ONE) ? (h1_r - ONE) : h1_r;

    blue_w = {1'b0, h1_r} - {1'b0, THIRD};
    if (blue_w[IN_W]) begin
      blue_w = blue_w + {1'b0, ONE};
    end else if (blue_w > {1'b0, ONE}) begin
      blue_w = blue_w - {1'b0, ONE};
    end
    t2_nxt[2] = blue_w[IN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      q2_r <= q2_nxt;
      p2_r <= p2_nxt;
      for (int i = 0; i < 3; i++) begin
        t2_r[i] <= t2_nxt[i];
      end
    end
  end

  // Stage 3: pick the piece of the hue curve. Flat pieces get a zero ramp
  // factor so that every channel reduces to base + (q-p)*factor.
  logic [IN_W-1:0] span;

  always_comb begin
    d3_nxt = q2_r - p2_r;
    span   = '0;
    for (int i = 0; i < 3; i++) begin
      if (t2_r[i] < SIXTH) begin
        base3_nxt[i] = p2_r;
        f3_nxt[i]    = ({1'b0, t2_r[i]} << 2) + ({1'b0, t2_r[i]} << 1);
      end else if (t2_r[i] < HALF) begin
        base3_nxt[i] = q2_r;
        f3_nxt[i]    = '0;
      end else if (t2_r[i] < TWO_THIRDS) begin
        span         = TWO_THIRDS - t2_r[i];
        base3_nxt[i] = p2_r;
        f3_nxt[i]    = ({1'b0, span} << 2) + ({1'b0, span} << 1);
      end else begin
        base3_nxt[i] = p2_r;
        f3_nxt[i]    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      d3_r <= d3_nxt;
      for (int i = 0; i < 3; i++) begin
        base3_r[i] <= base3_nxt[i];
        f3_r[i]    <= f3_nxt[i];
      end
    end
  end

  // Stage 4: numerator = base*ONE + (q-p)*factor, one multiplier per channel.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num4_nxt[i] = NUM_W'({base3_r[i], {FRAC_BITS{1'b0}}})
                  + NUM_W'(d3_r) * NUM_W'(f3_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      for (int i = 0; i < 3; i++) begin
        num4_r[i] <= num4_nxt[i];
      end
    end
  end

  // Stage 5: times 255 as shift and subtract, truncate, and saturate the
  // slight overshoot that the rounded breakpoints allow.
  logic [PROD_W-1:0] prod;
  logic [SCL_W-1:0]  scl;

  always_comb begin
    prod = '0;
    scl  = '0;
    for (int i = 0; i < 3; i++) begin
      prod = {num4_r[i], {CHANNEL_BITS{1'b0}}} - PROD_W'(num4_r[i]);
      scl  = prod[PROD_W-1 -: SCL_W];
      ch5_nxt[i] = (scl > SCL_W'(CMAX)) ? CMAX : scl[CHANNEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      for (int i = 0; i < 3; i++) begin
        ch5_r[i] <= ch5_nxt[i];
      end
    end
  end

endmodule

// ===== rtl/hsl2rgb_checker.sv =====
module hsl2rgb_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input hsl2rgb_pkg::hsl_in_t  in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input hsl2rgb_pkg::rgb_out_t out_data
);
  import hsl2rgb_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // Back-pressure only ever comes from a stalled result side.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while result side was free");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With no stall, an accepted item reaches the output.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall |=> out_valid)
    else $error("accepted item did not reach the output in time");

endmodule

bind hsl_to_rgb_converter_unit hsl2rgb_checker u_hsl2rgb_checker (.*);
